@@ hdl/binary_grid_component_counter_core_assert.svh @@
`ifndef BINARY_GRID_COMPONENT_COUNTER_CORE_ASSERT_SVH
`define BINARY_GRID_COMPONENT_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BGCC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BGCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bgcc_pkg.sv @@
package bgcc_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int GRID_CAP = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = $clog2(GRID_CAP);
    localparam int CNT_W    = $clog2(GRID_CAP + 1);
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int COLS_W   = $clog2(MAX_COLS + 1);
    localparam int CFG_W    = 7;
    localparam int TALLY_W  = 12;
    localparam int STACK_W  = ADDR_W + COL_W;

    typedef struct packed {
        logic [CNT_W-1:0]  loaded;
        logic [COLS_W-1:0] cols;
    } grid_cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] idx;
        logic [COL_W-1:0]  col;
    } stack_entry_t;

    typedef struct packed {
        logic busy;
        logic result_valid;
    } back_status_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_SCAN_RD,
        B_SCAN_CHK,
        B_POP_RD,
        B_POP_WAIT,
        B_NB_RD,
        B_NB_CHK,
        B_DONE
    } back_state_t;

    typedef enum logic [1:0] {
        NB_LEFT,
        NB_RIGHT,
        NB_UP,
        NB_DOWN
    } nb_dir_t;

endpackage

@@ hdl/bgcc_ram.sv @@
module bgcc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/bgcc_front.sv @@
module bgcc_front
    import bgcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              cell_is_land,
    input  logic              last_cell,
    input  logic [CFG_W-1:0]  cols_cfg,
    output logic              grid_we,
    output logic [ADDR_W-1:0] grid_waddr,
    output logic              grid_wdata,
    output logic              cmd_push,
    output grid_cmd_t         cmd
);

    logic [CNT_W-1:0]  loaded_reg;
    logic [CNT_W-1:0]  loaded_next;
    logic              room;
    logic [COLS_W-1:0] cols_eff;

    assign room = (loaded_reg < CNT_W'(GRID_CAP));

    always_comb
    begin
        if (cols_cfg == '0)
        begin
            cols_eff = COLS_W'(1);
        end
        else if (32'(cols_cfg) > MAX_COLS)
        begin
            cols_eff = COLS_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = COLS_W'(cols_cfg);
        end
    end

    assign grid_we    = accept && room;
    assign grid_waddr = loaded_reg[ADDR_W-1:0];
    assign grid_wdata = cell_is_land;
    assign cmd_push   = accept && last_cell;
    assign cmd.loaded = room ? loaded_reg + CNT_W'(1) : loaded_reg;
    assign cmd.cols   = cols_eff;

    always_comb
    begin
        loaded_next = loaded_reg;
        if (accept)
        begin
            if (last_cell)
            begin
                loaded_next = '0;
            end
            else if (room)
            begin
                loaded_next = loaded_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
        end
        else
        begin
            loaded_reg <= loaded_next;
        end
    end

endmodule

@@ hdl/bgcc_cmd_queue.sv @@
module bgcc_cmd_queue
    import bgcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  grid_cmd_t push_data,
    input  logic      pop,
    output grid_cmd_t pop_data,
    output logic      empty
);

    grid_cmd_t slot_reg [2];
    logic      wr_ptr_reg;
    logic      wr_ptr_next;
    logic      rd_ptr_reg;
    logic      rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic      do_push;
    logic      do_pop;

    assign empty    = (fill_reg == 2'd0);
    assign do_push  = push && (fill_reg != 2'd2);
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ hdl/bgcc_back.sv @@
module bgcc_back
    import bgcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_avail,
    input  grid_cmd_t          cmd,
    output logic               cmd_pop,
    output logic [ADDR_W-1:0]  grid_raddr,
    input  logic               grid_rdata,
    output back_status_t       status,
    output logic [TALLY_W-1:0] tally
);

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [CNT_W-1:0]  loaded_reg;
    logic [CNT_W-1:0]  loaded_next;
    logic [COLS_W-1:0] cols_reg;
    logic [COLS_W-1:0] cols_next;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic [CNT_W-1:0]  scan_idx_next;
    logic [COL_W-1:0]  scan_col_reg;
    logic [COL_W-1:0]  scan_col_next;
    logic [TALLY_W-1:0] tally_reg;
    logic [TALLY_W-1:0] tally_next;
    logic [CNT_W-1:0]  top_reg;
    logic [CNT_W-1:0]  top_next;
    logic [ADDR_W-1:0] cur_idx_reg;
    logic [ADDR_W-1:0] cur_idx_next;
    logic [COL_W-1:0]  cur_col_reg;
    logic [COL_W-1:0]  cur_col_next;
    nb_dir_t           nb_dir_reg;
    nb_dir_t           nb_dir_next;
    logic [ADDR_W-1:0] nb_addr_reg;
    logic [ADDR_W-1:0] nb_addr_next;
    logic [COL_W-1:0]  nb_col_reg;
    logic [COL_W-1:0]  nb_col_next;
    logic [CNT_W-1:0]  clr_idx_reg;
    logic [CNT_W-1:0]  clr_idx_next;
    logic [CNT_W-1:0]  clr_limit_reg;
    logic [CNT_W-1:0]  clr_limit_next;

    logic              vis_we;
    logic [ADDR_W-1:0] vis_waddr;
    logic              vis_wdata;
    logic [ADDR_W-1:0] vis_raddr;
    logic              vis_rdata;
    logic              stk_we;
    logic [ADDR_W-1:0] stk_waddr;
    stack_entry_t      stk_wdata;
    logic [ADDR_W-1:0] stk_raddr;
    stack_entry_t      stk_rdata;

    logic              nb_ok;
    logic [CNT_W-1:0]  nb_addr_c;
    logic [COL_W-1:0]  nb_col_c;
    logic              claim;
    logic              scan_end;
    logic              clr_end;
    logic              last_dir;
    logic [CNT_W-1:0]  scan_idx_inc;
    logic [COL_W-1:0]  scan_col_inc;

    bgcc_ram #(.WIDTH(1), .DEPTH(GRID_CAP)) u_visited (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    bgcc_ram #(.WIDTH(STACK_W), .DEPTH(GRID_CAP)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign claim    = grid_rdata && !vis_rdata;
    assign scan_end = (scan_idx_reg == loaded_reg);
    assign clr_end  = (clr_idx_reg == clr_limit_reg);
    assign last_dir = (nb_dir_reg == NB_DOWN);

    assign scan_idx_inc = scan_idx_reg + CNT_W'(1);
    assign scan_col_inc = ((COLS_W'(scan_col_reg) + COLS_W'(1)) == cols_reg)
                          ? '0 : scan_col_reg + COL_W'(1);

    always_comb
    begin
        nb_ok     = 1'b0;
        nb_addr_c = '0;
        nb_col_c  = cur_col_reg;
        case (nb_dir_reg)
            NB_LEFT:
            begin
                nb_ok     = (cur_col_reg != '0);
                nb_addr_c = CNT_W'(cur_idx_reg) - CNT_W'(1);
                nb_col_c  = cur_col_reg - COL_W'(1);
            end
            NB_RIGHT:
            begin
                nb_ok     = ((COLS_W'(cur_col_reg) + COLS_W'(1)) < cols_reg);
                nb_addr_c = CNT_W'(cur_idx_reg) + CNT_W'(1);
                nb_col_c  = cur_col_reg + COL_W'(1);
            end
            NB_UP:
            begin
                nb_ok     = (CNT_W'(cur_idx_reg) >= CNT_W'(cols_reg));
                nb_addr_c = CNT_W'(cur_idx_reg) - CNT_W'(cols_reg);
            end
            default:
            begin
                nb_ok     = 1'b1;
                nb_addr_c = CNT_W'(cur_idx_reg) + CNT_W'(cols_reg);
            end
        endcase
        nb_ok = nb_ok && (nb_addr_c < loaded_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR:
            begin
                if (clr_end)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (cmd_avail)
                begin
                    state_next = B_SCAN_RD;
                end
            end
            B_SCAN_RD:
            begin
                state_next = scan_end ? B_DONE : B_SCAN_CHK;
            end
            B_SCAN_CHK:
            begin
                state_next = claim ? B_POP_RD : B_SCAN_RD;
            end
            B_POP_RD:
            begin
                state_next = (top_reg == '0) ? B_SCAN_RD : B_POP_WAIT;
            end
            B_POP_WAIT:
            begin
                state_next = B_NB_RD;
            end
            B_NB_RD:
            begin
                if (nb_ok)
                begin
                    state_next = B_NB_CHK;
                end
                else if (last_dir)
                begin
                    state_next = B_POP_RD;
                end
            end
            B_NB_CHK:
            begin
                state_next = last_dir ? B_POP_RD : B_NB_RD;
            end
            B_DONE:
            begin
                state_next = B_CLEAR;
            end
            default:
            begin
                state_next = B_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        loaded_next    = loaded_reg;
        cols_next      = cols_reg;
        scan_idx_next  = scan_idx_reg;
        scan_col_next  = scan_col_reg;
        tally_next     = tally_reg;
        top_next       = top_reg;
        cur_idx_next   = cur_idx_reg;
        cur_col_next   = cur_col_reg;
        nb_dir_next    = nb_dir_reg;
        nb_addr_next   = nb_addr_reg;
        nb_col_next    = nb_col_reg;
        clr_idx_next   = clr_idx_reg;
        clr_limit_next = clr_limit_reg;
        cmd_pop        = 1'b0;
        grid_raddr     = scan_idx_reg[ADDR_W-1:0];
        vis_raddr      = scan_idx_reg[ADDR_W-1:0];
        vis_we         = 1'b0;
        vis_waddr      = scan_idx_reg[ADDR_W-1:0];
        vis_wdata      = 1'b1;
        stk_we         = 1'b0;
        stk_waddr      = top_reg[ADDR_W-1:0];
        stk_wdata.idx  = scan_idx_reg[ADDR_W-1:0];
        stk_wdata.col  = scan_col_reg;
        stk_raddr      = top_reg[ADDR_W-1:0] - ADDR_W'(1);
        unique case (state_reg)
            B_CLEAR:
            begin
                if (!clr_end)
                begin
                    vis_we       = 1'b1;
                    vis_waddr    = clr_idx_reg[ADDR_W-1:0];
                    vis_wdata    = 1'b0;
                    clr_idx_next = clr_idx_reg + CNT_W'(1);
                end
            end
            B_IDLE:
            begin
                if (cmd_avail)
                begin
                    cmd_pop       = 1'b1;
                    loaded_next   = cmd.loaded;
                    cols_next     = cmd.cols;
                    scan_idx_next = '0;
                    scan_col_next = '0;
                    tally_next    = '0;
                    top_next      = '0;
                end
            end
            B_SCAN_RD:
            begin
            end
            B_SCAN_CHK:
            begin
                if (claim)
                begin
                    vis_we     = 1'b1;
                    stk_we     = 1'b1;
                    top_next   = top_reg + CNT_W'(1);
                    tally_next = tally_reg + TALLY_W'(1);
                end
                else
                begin
                    scan_idx_next = scan_idx_inc;
                    scan_col_next = scan_col_inc;
                end
            end
            B_POP_RD:
            begin
                if (top_reg == '0)
                begin
                    scan_idx_next = scan_idx_inc;
                    scan_col_next = scan_col_inc;
                end
                else
                begin
                    top_next = top_reg - CNT_W'(1);
                end
            end
            B_POP_WAIT:
            begin
                cur_idx_next = stk_rdata.idx;
                cur_col_next = stk_rdata.col;
                nb_dir_next  = NB_LEFT;
            end
            B_NB_RD:
            begin
                grid_raddr   = nb_addr_c[ADDR_W-1:0];
                vis_raddr    = nb_addr_c[ADDR_W-1:0];
                nb_addr_next = nb_addr_c[ADDR_W-1:0];
                nb_col_next  = nb_col_c;
                if (!nb_ok && !last_dir)
                begin
                    nb_dir_next = nb_dir_t'(2'(nb_dir_reg) + 2'd1);
                end
            end
            B_NB_CHK:
            begin
                if (claim)
                begin
                    vis_we        = 1'b1;
                    vis_waddr     = nb_addr_reg;
                    stk_we        = 1'b1;
                    stk_wdata.idx = nb_addr_reg;
                    stk_wdata.col = nb_col_reg;
                    top_next      = top_reg + CNT_W'(1);
                end
                if (!last_dir)
                begin
                    nb_dir_next = nb_dir_t'(2'(nb_dir_reg) + 2'd1);
                end
            end
            B_DONE:
            begin
                clr_idx_next   = '0;
                clr_limit_next = loaded_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.busy         = (state_reg != B_IDLE);
    assign status.result_valid = (state_reg == B_DONE);
    assign tally               = tally_reg;

    always_ff @(posedge clk)
    begin
        loaded_reg   <= loaded_next;
        cols_reg     <= cols_next;
        scan_idx_reg <= scan_idx_next;
        scan_col_reg <= scan_col_next;
        tally_reg    <= tally_next;
        cur_idx_reg  <= cur_idx_next;
        cur_col_reg  <= cur_col_next;
        nb_addr_reg  <= nb_addr_next;
        nb_col_reg   <= nb_col_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            top_reg       <= '0;
            nb_dir_reg    <= NB_LEFT;
            clr_idx_reg   <= '0;
            clr_limit_reg <= CNT_W'(GRID_CAP);
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            nb_dir_reg    <= nb_dir_next;
            clr_idx_reg   <= clr_idx_next;
            clr_limit_reg <= clr_limit_next;
        end
    end

endmodule

@@ hdl/binary_grid_component_counter_core.sv @@
// Counts four-connected land regions of a binary grid. Cells enter in raster order, one
// beat per cycle while busy is low, and the beat with last_cell set closes the grid. Busy
// then stays high while the stored grid is scanned and flood-filled from an on-chip stack;
// the scan reads and checks each cell, and the fill takes each land cell through a stack pop
// plus a read and check of each of its neighbours inside the grid, all through simple
// dual-port RAMs with registered reads. The count is shown on island_count with
// result_valid, which is high for one cycle, and the receiver cannot stall it. A visited-map
// clear of one entry per cycle follows each grid over the cells loaded, and after reset a
// clear of all 4096 entries runs before the first cell is taken. The row width in
// grid_columns is sampled on the final cell and may be written whenever cfg_ready is high.
`include "binary_grid_component_counter_core_assert.svh"

module binary_grid_component_counter_core
    import bgcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cell_is_land,
    input  logic               last_cell,
    output logic               result_valid,
    output logic [TALLY_W-1:0] island_count,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data
);

    logic [CFG_W-1:0]  grid_columns_reg;
    logic              accept;
    logic              grid_we;
    logic [ADDR_W-1:0] grid_waddr;
    logic              grid_wdata;
    logic [ADDR_W-1:0] grid_raddr;
    logic              grid_rdata;
    logic              cmd_push;
    grid_cmd_t         cmd_in;
    grid_cmd_t         cmd_out;
    logic              cmd_pop;
    logic              q_empty;
    back_status_t      back_status;

    assign cfg_ready    = 1'b1;
    assign busy         = !q_empty || back_status.busy;
    assign accept       = start && !busy;
    assign result_valid = back_status.result_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_columns_reg <= CFG_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            grid_columns_reg <= cfg_data;
        end
    end

    bgcc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .cell_is_land (cell_is_land),
        .last_cell    (last_cell),
        .cols_cfg     (grid_columns_reg),
        .grid_we      (grid_we),
        .grid_waddr   (grid_waddr),
        .grid_wdata   (grid_wdata),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in)
    );

    bgcc_ram #(.WIDTH(1), .DEPTH(GRID_CAP)) u_grid (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    bgcc_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (q_empty)
    );

    bgcc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_avail  (!q_empty),
        .cmd        (cmd_out),
        .cmd_pop    (cmd_pop),
        .grid_raddr (grid_raddr),
        .grid_rdata (grid_rdata),
        .status     (back_status),
        .tally      (island_count)
    );

    `BGCC_ASSERT_NEXT(a_last_sets_busy, clk, rst_n, accept && last_cell, busy,
        "busy did not rise after the final cell")
    `BGCC_ASSERT_SAME(a_result_while_busy, clk, rst_n, result_valid, busy && q_empty,
        "result shown while the block was not working on a grid")
    `BGCC_ASSERT_NEXT(a_single_result, clk, rst_n, result_valid, !result_valid,
        "result strobe held for more than one cycle")
    `BGCC_ASSERT_SAME(a_no_push_when_busy, clk, rst_n, cmd_push, !busy,
        "grid command queued while the back end was busy")

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    import bgcc_pkg::*;

    typedef enum logic [1:0] {
        JOB_CELL,
        JOB_CFG,
        JOB_DRAIN
    } job_kind_t;

    typedef struct {
        job_kind_t        kind;
        logic             land;
        logic             last;
        logic [CFG_W-1:0] width;
        bit               may_idle;
    } job_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               cell_is_land;
    logic               last_cell;
    logic               result_valid;
    logic [TALLY_W-1:0] island_count;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data;

    binary_grid_component_counter_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cell_is_land (cell_is_land),
        .last_cell    (last_cell),
        .result_valid (result_valid),
        .island_count (island_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    job_t               job_q[$];
    logic [TALLY_W-1:0] count_q[$];
    bit                 land_mem[GRID_CAP];
    bit                 seen_mem[GRID_CAP];
    int unsigned        fill_stk[GRID_CAP];
    int unsigned        cells_in_grid;
    logic [CFG_W-1:0]   row_width;
    bit                 calm;
    bit                 cell_took;
    bit                 cfg_took;
    bit                 draining;
    int                 gap;
    int                 settle;
    int                 errors;
    int                 beats_sent;
    int                 grids_done;
    int                 writes_done;
    int                 cells_queued;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [TALLY_W-1:0] count_islands(input int unsigned loaded,
                                                         input logic [CFG_W-1:0] width);
        int unsigned cols;
        int unsigned top;
        int unsigned tally;
        int unsigned cur;
        int unsigned nb[4];
        bit          ok[4];
        cols = 32'(width);
        if (cols == 0)
            cols = 1;
        if (cols > MAX_COLS)
            cols = MAX_COLS;
        tally = 0;
        for (int i = 0; i < GRID_CAP; i++)
            seen_mem[i] = 0;
        for (int unsigned s = 0; s < loaded; s++) begin
            if (land_mem[s] && !seen_mem[s]) begin
                tally++;
                seen_mem[s] = 1;
                fill_stk[0] = s;
                top = 1;
                while (top > 0) begin
                    top--;
                    cur = fill_stk[top];
                    nb[0] = cur - 1;
                    ok[0] = (cur % cols) > 0;
                    nb[1] = cur + 1;
                    ok[1] = (cur % cols) + 1 < cols;
                    nb[2] = cur - cols;
                    ok[2] = cur >= cols;
                    nb[3] = cur + cols;
                    ok[3] = 1;
                    for (int d = 0; d < 4; d++) begin
                        if (ok[d] && nb[d] < loaded && land_mem[nb[d]] && !seen_mem[nb[d]]) begin
                            seen_mem[nb[d]] = 1;
                            fill_stk[top] = nb[d];
                            top++;
                        end
                    end
                end
            end
        end
        return tally[TALLY_W-1:0];
    endfunction

    always @(posedge clk) begin
        cell_took <= start && !busy;
        cfg_took  <= cfg_valid && cfg_ready;
        if (rst_n) begin
            if (result_valid) begin
                if (count_q.size() == 0)
                    report_mismatch($sformatf("unexpected result %0d", island_count));
                else if (island_count !== count_q[0]) begin
                    report_mismatch($sformatf("island_count %0d, want %0d",
                                              island_count, count_q[0]));
                    void'(count_q.pop_front());
                end
                else
                    void'(count_q.pop_front());
            end
            if (cfg_valid && cfg_ready) begin
                row_width = cfg_data;
                writes_done++;
            end
            if (start && !busy) begin
                beats_sent++;
                if (cells_in_grid < GRID_CAP) begin
                    land_mem[cells_in_grid] = cell_is_land;
                    cells_in_grid++;
                end
                if (last_cell) begin
                    count_q.push_back(count_islands(cells_in_grid, row_width));
                    cells_in_grid = 0;
                    grids_done++;
                end
            end
        end
    end

    always @(negedge clk) begin
        logic nstart;
        logic ncfg;
        job_t j;
        nstart = start;
        ncfg   = cfg_valid;
        if (rst_n) begin
            if (start && cell_took)
                nstart = 1'b0;
            if (cfg_valid && cfg_took)
                ncfg = 1'b0;
            if (!nstart && !ncfg) begin
                if (gap > 0)
                    gap--;
                else if (settle > 0)
                    settle--;
                else if (draining) begin
                    if (count_q.size() == 0) begin
                        draining = 0;
                        settle   = 64;
                    end
                end
                else if (job_q.size() > 0) begin
                    j = job_q.pop_front();
                    case (j.kind)
                        JOB_CELL: begin
                            nstart = 1'b1;
                            cell_is_land <= j.land;
                            last_cell    <= j.last;
                        end
                        JOB_CFG: begin
                            ncfg = 1'b1;
                            cfg_data <= j.width;
                        end
                        default: draining = 1;
                    endcase
                    if (j.may_idle && $urandom_range(0, 4) == 0)
                        gap = $urandom_range(1, 9);
                end
            end
        end
        start     <= nstart;
        cfg_valid <= ncfg;
    end

    task automatic add_cell(input int land, input int last);
        job_t j;
        j.kind     = JOB_CELL;
        j.land     = (land != 0);
        j.last     = (last != 0);
        j.width    = '0;
        j.may_idle = !calm;
        job_q.push_back(j);
        cells_queued++;
    endtask

    task automatic add_drain();
        job_t j;
        j.kind     = JOB_DRAIN;
        j.land     = 0;
        j.last     = 0;
        j.width    = '0;
        j.may_idle = !calm;
        job_q.push_back(j);
    endtask

    task automatic add_width(input logic [CFG_W-1:0] w);
        job_t j;
        add_drain();
        j.kind     = JOB_CFG;
        j.land     = 0;
        j.last     = 0;
        j.width    = w;
        j.may_idle = !calm;
        job_q.push_back(j);
    endtask

    task automatic add_random_cells(input int n, input int pct, input bit close);
        for (int i = 0; i < n; i++)
            add_cell(int'($urandom_range(0, 99) < pct), int'(close && (i == n - 1)));
    endtask

    initial begin
        int n;
        int split;
        int pct;
        rst_n        = 1'b0;
        start        = 1'b0;
        cell_is_land = 1'b0;
        last_cell    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        row_width    = 7'd64;
        cells_in_grid = 0;
        gap = 0;
        settle = 0;
        draining = 0;
        errors = 0;
        calm = 0;

        add_cell(1, 1);
        add_cell(0, 1);
        add_width(7'd0);
        add_cell(1, 0); add_cell(0, 0); add_cell(1, 0); add_cell(1, 0); add_cell(0, 1);
        add_width(7'd127);
        add_cell(1, 0); add_cell(1, 0); add_cell(0, 0); add_cell(1, 1);
        add_width(7'd3);
        add_cell(1, 0); add_cell(0, 0); add_cell(1, 0); add_cell(1, 0);
        add_cell(1, 0); add_cell(0, 0); add_cell(1, 1);
        add_cell(0, 0); add_cell(1, 0);
        add_width(7'd1);
        add_cell(1, 0); add_cell(0, 1);
        add_width(7'd64);
        // Eight full rows of checkerboard give a dense count with a short partial row after.
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < MAX_COLS; c++)
                add_cell(int'((r + c) % 2 == 0), 0);
        add_cell(1, 0); add_cell(1, 0); add_cell(0, 0); add_cell(1, 1);
        add_width(7'd8);
        add_random_cells(60, 50, 1);

        n = cells_queued;
        while (cells_queued < n + 800) begin
            if (cells_queued > n + 600)
                calm = 1;
            if ($urandom_range(0, 2) == 0)
                add_width($urandom_range(0, 5) == 0 ? CFG_W'($urandom_range(0, 127))
                                                    : CFG_W'($urandom_range(1, 12)));
            else if ($urandom_range(0, 5) == 0)
                add_drain();
            pct = $urandom_range(0, 2) * 40 + 10;
            n = n;
            split = $urandom_range(1, 90);
            if ($urandom_range(0, 7) == 0) begin
                add_random_cells(split, pct, 0);
                add_width(CFG_W'($urandom_range(1, 16)));
            end
            add_random_cells($urandom_range(1, 90), pct, 1);
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (job_q.size() == 0 && !start && !cfg_valid && !draining && settle == 0
              && count_q.size() == 0);
        repeat (5000) @(posedge clk);
        $display("Ran %0d cell beats over %0d grids with %0d row-width writes,",
                 beats_sent, grids_done, writes_done);
        $display("including a dense checkerboard, out-of-range widths and mid-grid width changes.");
        if (errors == 0 && count_q.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        #(8 * 3000000);
        $display("tb_top: errors");
        $finish;
    end

endmodule
